FILE: rtl/core/event_time_window_buffer_top_defines.svh
// Assertion macros shared by the checker of the event time window buffer.
`ifndef EVENT_TIME_WINDOW_BUFFER_TOP_DEFINES_SVH
`define EVENT_TIME_WINDOW_BUFFER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ETWB_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("etwb check failed");
// Next-cycle implication checked outside reset.
`define ETWB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("etwb check failed");
`endif

FILE: rtl/core/etwb_pkg.sv
// Package with the shared types and constants of the event time window buffer.
package etwb_pkg;
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_RENDER = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [7:0] SHADE_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] event_time;
        logic [9:0]  event_x;
        logic [9:0]  event_y;
    } cmd_t;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] shade;
        logic       has_pixel;
        logic       in_frame;
        logic       overflowed;
        logic       last;
    } result_t;
endpackage

FILE: rtl/core/etwb_front.sv
// Front end: command queue that accepts input transactions and drops unused opcodes.
module etwb_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  etwb_pkg::cmd_t cmd_in,
    input  logic           take,
    output logic           avail,
    output etwb_pkg::cmd_t cmd_out
);
    import etwb_pkg::*;

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       keep;
    logic       do_push;
    logic       do_pop;

    assign keep    = (cmd_in.opcode == OP_ADD) || (cmd_in.opcode == OP_RENDER)
                     || (cmd_in.opcode == OP_CLEAR);
    assign full    = (cnt_reg == 2'd2);
    assign avail   = (cnt_reg != 2'd0);
    assign cmd_out = q_reg[rd_reg];
    assign do_push = push && !full && keep;
    assign do_pop  = take && avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

FILE: rtl/core/etwb_div.sv
// Restoring divider that produces the 8-bit shade quotient one bit per cycle.
module etwb_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [7:0]  quotient
);
    // The quotient is known to fit in 8 bits since age never exceeds the divisor.
    logic [32:0] rem_reg;
    logic [39:0] num_reg;
    logic [31:0] den_reg;
    logic [7:0]  q_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted  = {rem_reg[31:0], num_reg[7]};
    assign trial    = shifted - {1'b0, den_reg};
    assign done     = busy_reg && (cnt_reg == 4'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            rem_reg  <= 33'd0;
            num_reg  <= 40'd0;
            den_reg  <= 32'd0;
            q_reg    <= 8'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd8;
            rem_reg  <= {1'b0, dividend[39:8]};
            num_reg  <= dividend;
            den_reg  <= divisor;
            q_reg    <= 8'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 4'd1;
                num_reg <= {num_reg[38:0], 1'b0};
                if (!trial[32])
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    q_reg   <= {q_reg[6:0], 1'b0};
                end
            end
        end
    end
endmodule

FILE: rtl/core/etwb_back.sv
// Back end: event ring memory, eviction, render walk and output register.
module etwb_back #(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    input  etwb_pkg::cmd_t    cmd,
    output logic              take,
    input  logic              cfg_clr,
    input  logic [31:0]       time_window,
    input  logic [10:0]       frame_width,
    input  logic [10:0]       frame_height,
    output logic              res_valid,
    input  logic              res_pop,
    output etwb_pkg::result_t res
);
    import etwb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EVRD, S_EVCHK, S_RDNEW, S_RD, S_DIV, S_OUT
    } state_t;

    logic [51:0]   ring [DEPTH];
    logic [51:0]   rdata_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic          wr_en;

    state_t        state_reg;
    logic [AW-1:0] newest_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [CW-1:0] k_reg;
    logic [31:0]   now_reg;
    cmd_t          cur_reg;
    result_t       res_reg;
    logic          rv_reg;
    logic          res_load;
    logic          div_start;
    logic          div_done;
    logic [7:0]    div_q;
    logic [39:0]   div_num;
    logic [32:0]   age_reg;

    logic [CW:0]   oldest_sum;
    logic [CW:0]   walk_sum;
    logic [AW-1:0] oldest;
    logic [AW-1:0] walk_addr;
    logic [AW-1:0] newest_inc;
    logic [32:0]   diff;
    logic [32:0]   adiff;
    logic [32:0]   age_raw;
    logic [CW-1:0] depth_c;

    // Ring positions are reduced modulo DEPTH with a single conditional subtract.
    assign depth_c    = CW'(DEPTH);
    assign oldest_sum = (CW+1)'(newest_reg) + (CW+1)'(DEPTH) + (CW+1)'(1)
                        - (CW+1)'(count_reg);
    assign oldest     = (oldest_sum >= (CW+1)'(DEPTH)) ? AW'(oldest_sum - (CW+1)'(DEPTH))
                                                      : AW'(oldest_sum);
    assign walk_sum   = (CW+1)'(newest_reg) + (CW+1)'(DEPTH) - (CW+1)'(k_reg);
    assign walk_addr  = (walk_sum >= (CW+1)'(DEPTH)) ? AW'(walk_sum - (CW+1)'(DEPTH))
                                                    : AW'(walk_sum);
    assign newest_inc = (newest_reg == AW'(DEPTH - 1)) ? '0 : newest_reg + AW'(1);
    assign diff       = {cur_reg.event_time[31], cur_reg.event_time}
                        - {rdata_reg[51], rdata_reg[51:20]};
    assign adiff      = diff[32] ? (33'd0 - diff) : diff;
    assign age_raw    = {now_reg[31], now_reg} - {rdata_reg[51], rdata_reg[51:20]};
    assign div_num    = {age_reg[31:0], 8'd0} - {8'd0, age_reg[31:0]};

    assign res_valid = rv_reg;
    assign res       = res_reg;
    assign take      = (state_reg == S_IDLE) && avail && !cfg_clr;
    assign wr_en     = (state_reg == S_EVCHK) && !(count_reg != '0 && adiff > {1'b0, time_window});
    assign res_load  = !cfg_clr && (!rv_reg || res_pop)
                       && ((state_reg == S_OUT) || ((state_reg == S_RDNEW) && (count_reg == '0)));

    // Walk address: oldest during eviction, newest minus k during a render.
    always_comb
    begin
        rd_en = 1'b0;
        raddr = oldest;
        case (state_reg)
            S_EVRD:
            begin
                rd_en = 1'b1;
                raddr = oldest;
            end
            S_RDNEW, S_RD:
            begin
                rd_en = 1'b1;
                raddr = walk_addr;
            end
            default:
            begin
                rd_en = 1'b0;
                raddr = oldest;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring[newest_inc] <= {cur_reg.event_time, cur_reg.event_x, cur_reg.event_y};
        end
        if (rd_en)
        begin
            rdata_reg <= ring[raddr];
        end
    end

    // age_reg[32] marks the cycle that launches the divider.
    assign div_start = (state_reg == S_DIV) && age_reg[32];

    etwb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (time_window),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            newest_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            rv_reg     <= 1'b0;
            now_reg    <= 32'd0;
            cur_reg    <= '0;
            res_reg    <= '0;
            age_reg    <= 33'd0;
        end
        else
        begin
            if (res_load)
            begin
                rv_reg <= 1'b1;
            end
            else if (rv_reg && res_pop)
            begin
                rv_reg <= 1'b0;
            end
            if (cfg_clr)
            begin
                newest_reg <= '0;
                count_reg  <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (avail)
                        begin
                            cur_reg <= cmd;
                            k_reg   <= '0;
                            if (cmd.opcode == OP_CLEAR)
                            begin
                                newest_reg <= '0;
                                count_reg  <= '0;
                                ovf_reg    <= 1'b0;
                            end
                            else if (cmd.opcode == OP_ADD)
                            begin
                                state_reg <= S_EVRD;
                            end
                            else
                            begin
                                state_reg <= S_RDNEW;
                            end
                        end
                    end
                    S_EVRD:
                    begin
                        state_reg <= S_EVCHK;
                    end
                    S_EVCHK:
                    begin
                        if (!wr_en)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_EVRD;
                        end
                        else
                        begin
                            newest_reg <= newest_inc;
                            if (count_reg >= depth_c)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    S_RDNEW:
                    begin
                        if (count_reg == '0)
                        begin
                            if (res_load)
                            begin
                                res_reg <= '{pixel_x: 10'd0, pixel_y: 10'd0, shade: 8'd0,
                                             has_pixel: 1'b0, in_frame: 1'b0,
                                             overflowed: ovf_reg, last: 1'b1};
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                    S_RD:
                    begin
                        // rdata_reg holds entry k; entry 0 sets the reference time.
                        if (k_reg == '0)
                        begin
                            now_reg <= rdata_reg[51:20];
                            age_reg <= 33'h1_0000_0000;
                        end
                        else if (age_raw[32])
                        begin
                            age_reg <= 33'h1_0000_0000;
                        end
                        else if (age_raw[31:0] > time_window)
                        begin
                            age_reg <= {1'b1, time_window};
                        end
                        else
                        begin
                            age_reg <= {1'b1, age_raw[31:0]};
                        end
                        state_reg <= S_DIV;
                    end
                    S_DIV:
                    begin
                        age_reg[32] <= 1'b0;
                        if (!age_reg[32] && div_done)
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    S_OUT:
                    begin
                        if (res_load)
                        begin
                            res_reg.pixel_x    <= rdata_reg[19:10];
                            res_reg.pixel_y    <= rdata_reg[9:0];
                            res_reg.shade      <= (time_window == 32'd0) ? 8'd0 : div_q;
                            res_reg.has_pixel  <= 1'b1;
                            res_reg.in_frame   <= ({1'b0, rdata_reg[19:10]} < frame_width)
                                                  && ({1'b0, rdata_reg[9:0]} < frame_height);
                            res_reg.overflowed <= ovf_reg;
                            res_reg.last       <= (k_reg + CW'(1) == count_reg);
                            if (k_reg + CW'(1) == count_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                k_reg     <= k_reg + CW'(1);
                                state_reg <= S_RDNEW;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end
endmodule

FILE: rtl/core/etwb_cfg.sv
// Config registers; a write to one also empties the event ring.
module etwb_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        cfg_clr,
    output logic [31:0] time_window,
    output logic [10:0] frame_width,
    output logic [10:0] frame_height
);
    import etwb_pkg::*;

    logic [31:0] window_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    assign time_window  = window_reg;
    assign frame_width  = width_reg;
    assign frame_height = height_reg;
    assign cfg_clr      = cfg_we && ((cfg_index == CFG_WINDOW) || (cfg_index == CFG_WIDTH)
                          || (cfg_index == CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd0;
            width_reg  <= 11'd0;
            height_reg <= 11'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW: window_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_HEIGHT: height_reg <= cfg_data[10:0];
                default:    window_reg <= window_reg;
            endcase
        end
    end
endmodule

FILE: rtl/core/event_time_window_buffer_top.sv
// An add leaving the queue reads and checks the oldest entry, once more per evicted
// event; each render result needs a memory read and an 8-step shade divide.
// Throughput: one command at a time in the back end; the two-entry command queue
// takes new transactions while it works. The shade divider sets the render rate.
// Reset (rst_n low, asynchronous) empties the ring, the queue and the result slot.
// Ring memory contents are not cleared; only entries counted as valid are read.
module event_time_window_buffer_top #(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] event_time,
    input  logic [9:0]  event_x,
    input  logic [9:0]  event_y,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  pixel_x,
    output logic [9:0]  pixel_y,
    output logic [7:0]  shade,
    output logic        has_pixel,
    output logic        in_frame,
    output logic        overflowed,
    output logic        last
);
    import etwb_pkg::*;

    cmd_t        cmd_in;
    cmd_t        cmd_q;
    logic        avail;
    logic        take;
    logic        cfg_clr;
    logic [31:0] time_window;
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic        res_valid;
    result_t     res;

    // The front queue decouples input transactions from the back end's walk.
    assign cmd_in = '{opcode: opcode, event_time: event_time,
                      event_x: event_x, event_y: event_y};

    etwb_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_clr      (cfg_clr),
        .time_window  (time_window),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    etwb_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .cmd_in  (cmd_in),
        .take    (take),
        .avail   (avail),
        .cmd_out (cmd_q)
    );

    // The back end holds one result register; a new result waits until it is popped.
    etwb_back #(
        .DEPTH (DEPTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (avail),
        .cmd          (cmd_q),
        .take         (take),
        .cfg_clr      (cfg_clr),
        .time_window  (time_window),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .res_valid    (res_valid),
        .res_pop      (pop),
        .res          (res)
    );

    assign empty      = !res_valid;
    assign pixel_x    = res.pixel_x;
    assign pixel_y    = res.pixel_y;
    assign shade      = res.shade;
    assign has_pixel  = res.has_pixel;
    assign in_frame   = res.in_frame;
    assign overflowed = res.overflowed;
    assign last       = res.last;
endmodule

FILE: rtl/core/etwb_checker.sv
// Port-level checker for the event time window buffer and its bind.
`include "event_time_window_buffer_top_defines.svh"
module etwb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       has_pixel,
    input logic       last,
    input logic [7:0] shade,
    input logic [9:0] pixel_x,
    input logic       in_frame
)
;
    `ETWB_ASSERT_IMPL(a_empty_result_last, clk, rst_n, !empty && !has_pixel, last)
    `ETWB_ASSERT_IMPL(a_empty_result_zero, clk, rst_n, !empty && !has_pixel, shade == 8'd0 && !in_frame)
    `ETWB_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(pixel_x))
endmodule

bind event_time_window_buffer_top etwb_checker u_etwb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .has_pixel (has_pixel),
    .last      (last),
    .shade     (shade),
    .pixel_x   (pixel_x),
    .in_frame  (in_frame)
);

FILE: bench/event_buffer_checker.sv
// Checker that predicts and compares the rendered pixels of the event time window buffer.
`timescale 1ns / 100ps

module event_buffer_checker
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] event_time,
    input  logic [9:0]  event_x,
    input  logic [9:0]  event_y,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        empty,
    input  logic        pop,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    input  logic [7:0]  shade,
    input  logic        has_pixel,
    input  logic        in_frame,
    input  logic        overflowed,
    input  logic        last,
    output int          errors,
    output int          pending
);
    import etwb_pkg::*;

    typedef struct {
        logic [31:0] stamp;
        logic [9:0]  col;
        logic [9:0]  row;
    } stored_event_t;

    stored_event_t stored_events[DEPTH];
    int            newest_idx;
    int            live_events;
    bit            overflow_seen;
    logic [31:0]   window_ticks;
    logic [10:0]   frame_w;
    logic [10:0]   frame_h;
    result_t       expected_pixels[$];

    assign pending = expected_pixels.size();

    task automatic report(string what, longint want, longint got);
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    function automatic longint stamp_distance(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return d;
    endfunction

    // Applies one accepted command to the shadow ring and queues the pixels it renders.
    task automatic predict_command(logic [1:0] op, logic [31:0] t, logic [9:0] x,
                                   logic [9:0] y);
        result_t px;
        longint  d;
        longint  age;
        int      slot;
        if (op == OP_ADD) begin
            while (live_events > 0) begin
                slot = (newest_idx + DEPTH + 1 - live_events) % DEPTH;
                d = stamp_distance(t, stored_events[slot].stamp);
                if (d < 0)
                    d = -d;
                if (d <= longint'(window_ticks))
                    break;
                live_events--;
            end
            if (live_events >= DEPTH) begin
                live_events = DEPTH - 1;
                overflow_seen = 1'b1;
            end
            newest_idx = (newest_idx + 1) % DEPTH;
            stored_events[newest_idx] = '{t, x, y};
            live_events++;
        end else if (op == OP_CLEAR) begin
            newest_idx = 0;
            live_events = 0;
            overflow_seen = 1'b0;
        end else if (op == OP_RENDER) begin
            if (live_events == 0) begin
                px = '0;
                px.overflowed = overflow_seen;
                px.last = 1'b1;
                expected_pixels.push_back(px);
            end else begin
                for (int k = 0; k < live_events; k++) begin
                    slot = (newest_idx + DEPTH - k) % DEPTH;
                    age = stamp_distance(stored_events[newest_idx].stamp,
                                         stored_events[slot].stamp);
                    if (age < 0)
                        age = 0;
                    if (age > longint'(window_ticks))
                        age = longint'(window_ticks);
                    px.pixel_x = stored_events[slot].col;
                    px.pixel_y = stored_events[slot].row;
                    px.shade = (window_ticks == 0) ? 8'd0
                             : 8'((longint'(SHADE_MAX) * age) / longint'(window_ticks));
                    px.has_pixel = 1'b1;
                    px.in_frame = ({1'b0, px.pixel_x} < frame_w) && ({1'b0, px.pixel_y} < frame_h);
                    px.overflowed = overflow_seen;
                    px.last = (k + 1 == live_events);
                    expected_pixels.push_back(px);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            errors = 0;
            newest_idx = 0;
            live_events = 0;
            overflow_seen = 1'b0;
            window_ticks = '0;
            frame_w = '0;
            frame_h = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_we && (cfg_index == CFG_WINDOW || cfg_index == CFG_WIDTH
                           || cfg_index == CFG_HEIGHT)) begin
                if (cfg_index == CFG_WINDOW)
                    window_ticks = cfg_data;
                else if (cfg_index == CFG_WIDTH)
                    frame_w = cfg_data[10:0];
                else
                    frame_h = cfg_data[10:0];
                newest_idx = 0;
                live_events = 0;
                overflow_seen = 1'b0;
            end
            if (push && !full)
                predict_command(opcode, event_time, event_x, event_y);
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    $display("unexpected pixel transaction at %0t", $realtime);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.pixel_x)
                        report("pixel_x", want.pixel_x, pixel_x);
                    if (pixel_y !== want.pixel_y)
                        report("pixel_y", want.pixel_y, pixel_y);
                    if (shade !== want.shade)
                        report("shade", want.shade, shade);
                    if (has_pixel !== want.has_pixel)
                        report("has_pixel", want.has_pixel, has_pixel);
                    if (in_frame !== want.in_frame)
                        report("in_frame", want.in_frame, in_frame);
                    if (overflowed !== want.overflowed)
                        report("overflowed", want.overflowed, overflowed);
                    if (last !== want.last)
                        report("last", want.last, last);
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench top that drives commands and configuration into the event time window buffer.
`timescale 1ns / 100ps

module tb;
    import etwb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  opcode;
    logic [31:0] event_time;
    logic [9:0]  event_x;
    logic [9:0]  event_y;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        empty;
    logic        pop;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [7:0]  shade;
    logic        has_pixel;
    logic        in_frame;
    logic        overflowed;
    logic        last;
    int          errors;
    int          pending;

    // When set, neither side idles, so back-to-back transactions are exercised.
    bit          steady;
    int          pop_hold;
    int          sent;

    event_time_window_buffer_top i_dut (.*);

    event_buffer_checker i_checker (.*);

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    // Pixel receiver: mostly ready, with short stalls and now and then a long one.
    always @(negedge clk) begin
        if (!rst_n || steady) begin
            pop <= rst_n;
        end else if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0:       begin pop_hold = $urandom_range(20, 80); pop <= 1'b0; end
                1, 2, 3: pop <= 1'b0;
                default: pop <= 1'b1;
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (steady || r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one command and holds it until the buffer accepts the transaction.
    task automatic send(logic [1:0] op, logic [31:0] t, logic [9:0] x, logic [9:0] y);
        int g;
        g = pick_gap();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        event_time <= t;
        event_x <= x;
        event_y <= y;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        if (op != 2'd3)
            sent++;
    endtask

    // An add can still be evicting when the last pixel has left; let it finish before
    // the registers change under it.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    // Each of these register writes also empties the ring, so this starts a fresh phase.
    task automatic configure(logic [31:0] win, logic [10:0] w, logic [10:0] h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_WINDOW;
        cfg_data <= win;
        @(negedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= {21'd0, w};
        @(negedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= {21'd0, h};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly bursts of adds with nearby timestamps closed by a render, so the ring fills,
    // evicts and overflows; the rest is clears, arbitrary commands and add-render pairs.
    task automatic random_traffic(int count, logic [31:0] win);
        int          kind;
        int          burst;
        logic [31:0] stamp;
        logic [31:0] stride;
        stride = (win > 32'd4000000) ? 32'd1000000 : win / 4;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            steady = ($urandom_range(0, 7) == 0);
            if (kind < 7) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70)
                                                    : $urandom_range(1, 12);
                stamp = $urandom;
                for (int i = 0; i < burst; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        stamp = stamp - $urandom_range(0, stride);
                    else
                        stamp = stamp + $urandom_range(0, stride);
                    send(OP_ADD, stamp, 10'($urandom), 10'($urandom));
                end
                send(OP_RENDER, $urandom, 10'($urandom), 10'($urandom));
            end else if (kind == 7) begin
                send(OP_CLEAR, $urandom, 10'($urandom), 10'($urandom));
            end else if (kind == 8) begin
                send(2'($urandom), $urandom, 10'($urandom), 10'($urandom));
            end else begin
                send(OP_ADD, $urandom, 10'($urandom), 10'($urandom));
                send(OP_RENDER, $urandom, 10'($urandom), 10'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        opcode = OP_ADD;
        event_time = '0;
        event_x = '0;
        event_y = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        steady = 1'b0;
        pop_hold = 0;
        sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: timestamp and coordinate extremes, empty renders, the unused
        // opcode, a clear, negative ages clamped to zero, against a frame of 640 by 480.
        configure(32'd1000, 11'd640, 11'd480);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);
        send(OP_ADD, 32'h8000_0000, 10'd0, 10'd0);
        send(OP_ADD, 32'h7FFF_FFFF, 10'd1023, 10'd1023);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);
        send(2'd3, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);
        send(OP_CLEAR, 32'd0, 10'd0, 10'd0);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);
        send(OP_ADD, 32'd10, 10'd639, 10'd479);
        send(OP_ADD, 32'd500, 10'd640, 10'd480);
        send(OP_ADD, 32'd1010, 10'd0, 10'd479);
        send(OP_ADD, 32'd5, 10'd639, 10'd0);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);
        send(OP_ADD, 32'd2100, 10'd3, 10'd4);
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);

        // A write to the unused register index must change nothing.
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= 2'd3;
        cfg_data <= 32'hFFFF_FFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
        send(OP_RENDER, 32'd0, 10'd0, 10'd0);

        configure(32'd0, 11'd0, 11'd0);
        random_traffic(90, 32'd0);
        configure(32'hFFFF_FFFF, 11'd1024, 11'd1024);
        random_traffic(180, 32'hFFFF_FFFF);
        configure(32'd100, 11'd1, 11'd1);
        random_traffic(270, 32'd100);
        configure(32'd1, 11'd1023, 11'd2047);
        random_traffic(350, 32'd1);
        for (int p = 0; p < 2; p++) begin
            configure(32'($urandom_range(1, 1 << 20)), 11'($urandom_range(0, 1024)),
                      11'($urandom_range(0, 1024)));
            random_traffic(430 + 80 * p, i_checker.window_ticks);
        end

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hang; far beyond the slowest legal run.
    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/etwb_pkg.sv
rtl/core/etwb_front.sv
rtl/core/etwb_div.sv
rtl/core/etwb_back.sv
rtl/core/etwb_cfg.sv
rtl/core/event_time_window_buffer_top.sv
rtl/core/etwb_checker.sv
bench/event_buffer_checker.sv
bench/tb.sv
